/* src/smbf_pkg.sv */
// shared types, register map and microcode program of the seen-message filter
package smbf_pkg;

    typedef struct packed {
        logic        op;
        logic [31:0] page;
        logic [31:0] index;
        logic [31:0] msg_id;
        logic        activate_value;
    } smbf_req_t;

    typedef struct packed {
        logic handled;
        logic unseen;
        logic enabled;
        logic activated;
        logic skipping;
        logic dirty;
    } smbf_rsp_t;

    typedef struct packed {
        logic        filter_loaded;
        logic        direct_mode;
        logic [20:0] msg_count;
        logic        skip_unseen;
        logic        stop_on_unseen;
        logic        paused;
    } smbf_cfg_t;

    localparam int unsigned REG_AW = 5;

    typedef enum logic [2:0] {
        REG_FILTER_LOADED  = 3'd0,
        REG_DIRECT_MODE    = 3'd1,
        REG_MSG_COUNT      = 3'd2,
        REG_SKIP_UNSEEN    = 3'd3,
        REG_STOP_ON_UNSEEN = 3'd4,
        REG_PAUSED         = 3'd5
    } smbf_reg_t;

    localparam logic [31:0] KNUTH_MUL = 32'd2654435761;
    localparam int unsigned H1_SHIFT  = 7;
    localparam int unsigned H2_SHIFT  = 15;

    // remainder is built one 4-bit digit per step
    localparam int unsigned DIGIT_BITS = 4;
    localparam int unsigned DIGITS     = 32 / DIGIT_BITS;
    localparam int unsigned DIG_CNT_W  = $clog2(DIGITS);

    typedef logic [3:0] step_t;

    localparam step_t ST_CLR      = 4'd0;
    localparam step_t ST_IDLE     = 4'd1;
    localparam step_t ST_DISPATCH = 4'd2;
    localparam step_t ST_MODE     = 4'd3;
    localparam step_t ST_HASH1    = 4'd4;
    localparam step_t ST_HASH2    = 4'd5;
    localparam step_t ST_MODLD    = 4'd6;
    localparam step_t ST_MOD      = 4'd7;
    localparam step_t ST_RD       = 4'd8;
    localparam step_t ST_TS       = 4'd9;
    localparam step_t ST_WRAP     = 4'd10;
    localparam step_t ST_APPLY    = 4'd11;
    localparam step_t ST_DIRECT   = 4'd12;
    localparam step_t ST_FIN      = 4'd13;

    typedef enum logic [3:0] {
        COND_ALWAYS,
        COND_CLR_MORE,
        COND_NO_REQ,
        COND_NOT_EVENT,
        COND_DIRECT,
        COND_REJECT,
        COND_DIG_MORE,
        COND_PROBE_MORE,
        COND_OUT_BUSY
    } smbf_cond_t;

    typedef struct packed {
        smbf_cond_t cond;
        step_t      jump;
        step_t      next;
        logic       ready;
        logic       clr_wr;
        logic       set_act;
        logic       mul_page;
        logic       mul_index;
        logic       mod_load;
        logic       mod_step;
        logic       load_id;
        logic       mem_rd;
        logic       mem_ts;
        logic       wrap_fix;
        logic       apply;
        logic       emit;
    } smbf_ctrl_t;

    typedef struct packed {
        logic clr_more;
        logic not_event;
        logic direct;
        logic reject;
        logic dig_more;
        logic probe_more;
    } smbf_flags_t;

    // control store: jump taken when cond holds, else next
    function automatic smbf_ctrl_t ucode(input step_t s);
        smbf_ctrl_t w;
        w = '0;
        w.cond = COND_ALWAYS;
        unique case (s)
            ST_CLR: begin
                w.clr_wr = 1'b1;
                w.cond = COND_CLR_MORE; w.jump = ST_CLR; w.next = ST_IDLE;
            end
            ST_IDLE: begin
                w.ready = 1'b1;
                w.cond = COND_NO_REQ; w.jump = ST_IDLE; w.next = ST_DISPATCH;
            end
            ST_DISPATCH: begin
                w.set_act = 1'b1;
                w.cond = COND_NOT_EVENT; w.jump = ST_FIN; w.next = ST_MODE;
            end
            ST_MODE: begin
                w.cond = COND_DIRECT; w.jump = ST_DIRECT; w.next = ST_HASH1;
            end
            ST_HASH1: begin
                w.mul_page = 1'b1;
                w.jump = ST_HASH2; w.next = ST_HASH2;
            end
            ST_HASH2: begin
                w.mul_index = 1'b1;
                w.jump = ST_MODLD; w.next = ST_MODLD;
            end
            ST_MODLD: begin
                w.mod_load = 1'b1;
                w.jump = ST_MOD; w.next = ST_MOD;
            end
            ST_MOD: begin
                w.mod_step = 1'b1;
                w.cond = COND_DIG_MORE; w.jump = ST_MOD; w.next = ST_RD;
            end
            ST_RD: begin
                w.mem_rd = 1'b1;
                w.jump = ST_TS; w.next = ST_TS;
            end
            ST_TS: begin
                w.mem_ts = 1'b1;
                w.jump = ST_WRAP; w.next = ST_WRAP;
            end
            ST_WRAP: begin
                w.wrap_fix = 1'b1;
                w.cond = COND_PROBE_MORE; w.jump = ST_RD; w.next = ST_APPLY;
            end
            ST_APPLY: begin
                w.apply = 1'b1;
                w.jump = ST_FIN; w.next = ST_FIN;
            end
            ST_DIRECT: begin
                w.load_id = 1'b1;
                w.cond = COND_REJECT; w.jump = ST_FIN; w.next = ST_RD;
            end
            ST_FIN: begin
                w.emit = 1'b1;
                w.cond = COND_OUT_BUSY; w.jump = ST_FIN; w.next = ST_IDLE;
            end
            default: begin
                w.jump = ST_IDLE; w.next = ST_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

/* src/seen_message_bloom_filter.sv */
// top level: request/result channels, register port, output stage and sequencer
//
//  channel   direction  handshake        payload
//  s_*       in         s_valid/s_ready  smbf_req_t (op, page, index, msg_id, activate_value)
//  m_*       out        m_valid/m_ready  smbf_rsp_t (handled .. dirty)
//  apb       in         psel/penable     six config registers at 4*i
//
//  bloom request: the sequential digit-serial remainder (8 steps)
//  and eight read/test/advance probe triples on the single bitmap
//  direct request: one probe at msg_id unless rejected; ignored or activation request goes to the finish step
//  after reset a clearing pass writes (FILTER_BITS+7)/8 bytes with s_ready low;
//  register writes are taken throughout
//  one request in flight; the next is taken while a finished result waits in m_*
module seen_message_bloom_filter #(
    parameter int FILTER_BITS = 1355477,
    parameter int PROBES      = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  smbf_pkg::smbf_req_t               s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output smbf_pkg::smbf_rsp_t               m_data,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [smbf_pkg::REG_AW-1:0]       paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    smbf_pkg::smbf_cfg_t   cfg_reg;
    smbf_pkg::smbf_ctrl_t  cw;
    smbf_pkg::smbf_flags_t flags;
    smbf_pkg::smbf_rsp_t   rsp, m_data_reg;
    smbf_pkg::smbf_reg_t   reg_idx;
    logic                  m_valid_reg;
    logic                  out_busy;
    logic                  accept;
    logic                  cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = smbf_pkg::smbf_reg_t'(paddr[smbf_pkg::REG_AW-1:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.filter_loaded  <= 1'b0;
            cfg_reg.direct_mode    <= 1'b0;
            cfg_reg.msg_count      <= '0;
            cfg_reg.skip_unseen    <= 1'b0;
            cfg_reg.stop_on_unseen <= 1'b1;
            cfg_reg.paused         <= 1'b0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                smbf_pkg::REG_FILTER_LOADED:  cfg_reg.filter_loaded  <= pwdata[0];
                smbf_pkg::REG_DIRECT_MODE:    cfg_reg.direct_mode    <= pwdata[0];
                smbf_pkg::REG_MSG_COUNT:      cfg_reg.msg_count      <= pwdata[20:0];
                smbf_pkg::REG_SKIP_UNSEEN:    cfg_reg.skip_unseen    <= pwdata[0];
                smbf_pkg::REG_STOP_ON_UNSEEN: cfg_reg.stop_on_unseen <= pwdata[0];
                smbf_pkg::REG_PAUSED:         cfg_reg.paused         <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            smbf_pkg::REG_FILTER_LOADED:  prdata = 32'(cfg_reg.filter_loaded);
            smbf_pkg::REG_DIRECT_MODE:    prdata = 32'(cfg_reg.direct_mode);
            smbf_pkg::REG_MSG_COUNT:      prdata = 32'(cfg_reg.msg_count);
            smbf_pkg::REG_SKIP_UNSEEN:    prdata = 32'(cfg_reg.skip_unseen);
            smbf_pkg::REG_STOP_ON_UNSEEN: prdata = 32'(cfg_reg.stop_on_unseen);
            smbf_pkg::REG_PAUSED:         prdata = 32'(cfg_reg.paused);
            default:                      prdata = '0;
        endcase
    end

    assign s_ready  = cw.ready;
    assign accept   = s_valid && cw.ready;
    assign out_busy = m_valid_reg && !m_ready;

    smbf_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .flags    (flags),
        .req      (s_valid),
        .out_busy (out_busy),
        .cw       (cw)
    );

    smbf_dp #(
        .FILTER_BITS (FILTER_BITS),
        .PROBES      (PROBES)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cw      (cw),
        .accept  (accept),
        .req_in  (s_data),
        .cfg     (cfg_reg),
        .flags   (flags),
        .rsp     (rsp)
    );

    // result stage, loaded when the sequencer finishes and the slot is free
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cw.emit && !out_busy) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cw.emit && !out_busy) begin
            m_data_reg <= rsp;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTH
    a_result_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(cw.emit))
        else $error("result raised outside the finish step");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("sequencer stayed idle after taking a request");
`endif

endmodule

/* src/smbf_bitmap.sv */
// byte-wide bitmap memory, one write port and one registered read port
module smbf_bitmap #(
    parameter int DEPTH  = 169435,
    parameter int ADDR_W = 18
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [7:0]        wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [7:0]        rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/smbf_seq.sv */
// microcode sequencer: step counter, control store lookup and branch logic
module smbf_seq (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  smbf_pkg::smbf_flags_t flags,
    input  logic                  req,
    input  logic                  out_busy,
    output smbf_pkg::smbf_ctrl_t  cw
);

    smbf_pkg::step_t step_reg, step_next;
    logic            taken;

    assign cw = smbf_pkg::ucode(step_reg);

    always_comb begin
        unique case (cw.cond)
            smbf_pkg::COND_ALWAYS:     taken = 1'b1;
            smbf_pkg::COND_CLR_MORE:   taken = flags.clr_more;
            smbf_pkg::COND_NO_REQ:     taken = !req;
            smbf_pkg::COND_NOT_EVENT:  taken = flags.not_event;
            smbf_pkg::COND_DIRECT:     taken = flags.direct;
            smbf_pkg::COND_REJECT:     taken = flags.reject;
            smbf_pkg::COND_DIG_MORE:   taken = flags.dig_more;
            smbf_pkg::COND_PROBE_MORE: taken = flags.probe_more;
            smbf_pkg::COND_OUT_BUSY:   taken = out_busy;
            default:                   taken = 1'b1;
        endcase
        step_next = taken ? cw.jump : cw.next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= smbf_pkg::ST_CLR;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

/* src/smbf_dp.sv */
// datapath: hashing, remainder lanes, probe positions, bitmap access and skip flags
module smbf_dp #(
    parameter int FILTER_BITS = 1355477,
    parameter int PROBES      = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  smbf_pkg::smbf_ctrl_t  cw,
    input  logic                  accept,
    input  smbf_pkg::smbf_req_t   req_in,
    input  smbf_pkg::smbf_cfg_t   cfg,
    output smbf_pkg::smbf_flags_t flags,
    output smbf_pkg::smbf_rsp_t   rsp
);

    localparam int POS_W       = $clog2(FILTER_BITS);
    localparam int STORE_BYTES = (FILTER_BITS + 7) / 8;
    localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int PROBE_W     = (PROBES > 1) ? $clog2(PROBES) : 1;
    localparam logic [POS_W:0]   NB       = (POS_W + 1)'(FILTER_BITS);
    localparam logic [POS_W-1:0] WRAP_REM = POS_W'((64'd1 << 32) % 64'(FILTER_BITS));
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BYTES - 1);

    smbf_pkg::smbf_req_t req_reg;

    logic [31:0]       h1_reg, h2_reg, s_reg, q1_reg, q2_reg;
    logic              carry_reg;
    logic [POS_W-1:0]  pos_reg, h2m_reg;
    logic [smbf_pkg::DIG_CNT_W-1:0] dig_cnt_reg;
    logic [PROBE_W-1:0] probe_cnt_reg;
    logic [ADDR_W-1:0] clr_addr_reg, addr_reg;
    logic [2:0]        bit_reg;
    logic              handled_reg, unseen_reg, enabled_reg, activated_reg, changed_reg;

    logic [31:0]       mul_key;
    logic [63:0]       product;
    logic [POS_W:0]    adv_sum, adv_red, wrap_diff, wrap_res;
    logic [32:0]       s_sum;
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [7:0]        mem_wdata, mem_rdata;
    logic              bit_set;

    // shift one 4-bit digit into a remainder modulo FILTER_BITS
    function automatic logic [POS_W-1:0] mod_digit(input logic [POS_W-1:0] r,
                                                   input logic [3:0] d);
        logic [POS_W:0]   t;
        logic [POS_W-1:0] acc;
        acc = r;
        for (int k = 3; k >= 0; k--) begin
            t = {acc, d[k]};
            if (t >= NB) begin
                t = t - NB;
            end
            acc = t[POS_W-1:0];
        end
        return acc;
    endfunction

    assign mul_key = cw.mul_page ? req_reg.page : req_reg.index;
    assign product = mul_key * smbf_pkg::KNUTH_MUL;

    always_comb begin
        adv_sum   = {1'b0, pos_reg} + {1'b0, h2m_reg};
        adv_red   = (adv_sum >= NB) ? adv_sum - NB : adv_sum;
        s_sum     = {1'b0, s_reg} + {1'b0, h2_reg};
        // a wrap of the 32-bit sum takes 2^32 mod FILTER_BITS off the remainder
        wrap_diff = {1'b0, pos_reg} - {1'b0, WRAP_REM};
        wrap_res  = wrap_diff[POS_W] ? wrap_diff + NB : wrap_diff;
    end

    assign bit_set   = mem_rdata[bit_reg];
    assign mem_we    = cw.clr_wr | cw.mem_ts;
    assign mem_waddr = cw.clr_wr ? clr_addr_reg : addr_reg;
    assign mem_wdata = cw.clr_wr ? 8'h00 : (mem_rdata | (8'b1 << bit_reg));
    assign mem_re    = cw.mem_rd;
    assign mem_raddr = ADDR_W'(pos_reg >> 3);

    smbf_bitmap #(
        .DEPTH  (STORE_BYTES),
        .ADDR_W (ADDR_W)
    ) u_bitmap (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // control state and skip flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg  <= '0;
            dig_cnt_reg   <= '0;
            probe_cnt_reg <= '0;
            handled_reg   <= 1'b0;
            unseen_reg    <= 1'b0;
            enabled_reg   <= 1'b1;
            activated_reg <= 1'b0;
            changed_reg   <= 1'b0;
        end else begin
            if (cw.clr_wr) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (accept) begin
                handled_reg <= 1'b0;
                unseen_reg  <= 1'b0;
            end
            if (cw.set_act && req_reg.op) begin
                activated_reg <= req_reg.activate_value;
            end
            if (cw.mod_load) begin
                dig_cnt_reg   <= smbf_pkg::DIG_CNT_W'(smbf_pkg::DIGITS - 1);
                probe_cnt_reg <= PROBE_W'(PROBES - 1);
            end
            if (cw.mod_step) begin
                dig_cnt_reg <= dig_cnt_reg - 1'b1;
            end
            if (cw.load_id) begin
                probe_cnt_reg <= '0;
            end
            if (cw.wrap_fix) begin
                probe_cnt_reg <= probe_cnt_reg - 1'b1;
            end
            if (cw.mem_ts && !bit_set) begin
                unseen_reg <= 1'b1;
            end
            if (cw.apply) begin
                handled_reg <= 1'b1;
                if (unseen_reg) begin
                    changed_reg <= 1'b1;
                end
                if (unseen_reg && !cfg.skip_unseen) begin
                    if (cfg.stop_on_unseen) begin
                        activated_reg <= 1'b0;
                    end
                    enabled_reg <= 1'b0;
                end else begin
                    enabled_reg <= 1'b1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg <= req_in;
        end
        if (cw.mul_page) begin
            h1_reg <= product[smbf_pkg::H1_SHIFT +: 32];
        end
        if (cw.mul_index) begin
            h2_reg <= product[smbf_pkg::H2_SHIFT +: 32];
        end
        if (cw.mod_load) begin
            q1_reg  <= h1_reg;
            q2_reg  <= h2_reg;
            s_reg   <= h1_reg;
            pos_reg <= '0;
            h2m_reg <= '0;
        end
        if (cw.mod_step) begin
            pos_reg <= mod_digit(pos_reg, q1_reg[31 -: smbf_pkg::DIGIT_BITS]);
            h2m_reg <= mod_digit(h2m_reg, q2_reg[31 -: smbf_pkg::DIGIT_BITS]);
            q1_reg  <= q1_reg << smbf_pkg::DIGIT_BITS;
            q2_reg  <= q2_reg << smbf_pkg::DIGIT_BITS;
        end
        if (cw.load_id) begin
            pos_reg <= POS_W'(req_reg.msg_id);
            h2m_reg <= '0;
        end
        if (cw.mem_rd) begin
            addr_reg <= mem_raddr;
            bit_reg  <= pos_reg[2:0];
        end
        if (cw.mem_ts) begin
            pos_reg   <= adv_red[POS_W-1:0];
            s_reg     <= s_sum[31:0];
            carry_reg <= s_sum[32];
        end
        if (cw.wrap_fix && carry_reg) begin
            pos_reg <= wrap_res[POS_W-1:0];
        end
    end

    assign flags.clr_more   = clr_addr_reg != LAST_ADDR;
    assign flags.not_event  = req_reg.op || !cfg.filter_loaded;
    assign flags.direct     = cfg.direct_mode;
    assign flags.reject     = cfg.paused
                              || (req_reg.msg_id >= {11'b0, cfg.msg_count})
                              || (req_reg.msg_id >= 32'(FILTER_BITS));
    assign flags.dig_more   = dig_cnt_reg != '0;
    assign flags.probe_more = probe_cnt_reg != '0;

    assign rsp.handled   = handled_reg;
    assign rsp.unseen    = unseen_reg;
    assign rsp.enabled   = enabled_reg;
    assign rsp.activated = activated_reg;
    assign rsp.skipping  = enabled_reg & activated_reg;
    assign rsp.dirty     = changed_reg;

`ifndef SYNTH
    a_mod_lanes_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        cw.mod_step |=> ({1'b0, pos_reg} < NB) && ({1'b0, h2m_reg} < NB))
        else $error("remainder lane left range after digit step");

    a_probe_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cw.wrap_fix && !cfg.direct_mode |=> {1'b0, pos_reg} < NB)
        else $error("next probe position not below filter size");
`endif

endmodule
